// File: hdl/epr_pkg.sv
// Shared types and constants of the escaped packet receiver.
// Used by every module of the block; depends on nothing.
package epr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int BUF_ADDR_W   = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int INDEX_W      = 5;
  localparam logic [7:0] ADDR_BASE = 8'd48;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ACCEPT   = 2'd1;
  localparam logic [1:0] EV_MISMATCH = 2'd2;

  localparam logic [1:0] REG_BOT_ID      = 2'd0;
  localparam logic [1:0] REG_ESCAPE_BYTE = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTE = 2'd2;
  localparam logic [1:0] REG_END_BYTE    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESCAPE,
    ST_CHECK,
    ST_DEST,
    ST_SOURCE,
    ST_PORT,
    ST_DATA,
    ST_DATAESC
  } parse_state_t;

  typedef struct packed {
    logic [3:0] bot_id;
    logic [7:0] escape_byte;
    logic [7:0] header_byte;
    logic [7:0] end_byte;
  } config_t;

  typedef struct packed {
    logic               operation;
    logic [7:0]         rx_byte;
    logic               line_error;
    logic [INDEX_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    logic [1:0] packet_event;
    logic       packet_ready;
    logic [5:0] packet_length;
    logic [7:0] source_address;
    logic [7:0] port_number;
    logic [7:0] read_data;
    logic [7:0] received_count;
    logic [7:0] accepted_count;
    logic [7:0] mismatch_count;
  } result_t;

  // Buffer write from the parser.
  typedef struct packed {
    logic                  en;
    logic [BUF_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } buf_write_t;

  // Parser status after the current request is applied.
  typedef struct packed {
    logic [1:0]        packet_event;
    logic              ready;
    logic [FILL_W-1:0] fill;
    logic [7:0]        source;
    logic [7:0]        port;
    logic [7:0]        received;
    logic [7:0]        accepted;
    logic [7:0]        mismatched;
  } parse_status_t;

endpackage

// File: hdl/epr_parser.sv
// Frame parser: state machine, running check, packet registers and counters.
// Depends on epr_pkg.
module epr_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  epr_pkg::request_t      request,
  input  epr_pkg::config_t       cfg,
  output epr_pkg::buf_write_t    buf_write,
  output epr_pkg::parse_status_t status
);

  epr_pkg::parse_state_t state, state_next;
  logic [7:0]                  check, check_next;
  logic [epr_pkg::FILL_W-1:0]  fill, fill_next;
  logic                        ready, ready_next;
  logic [7:0]                  source, source_next;
  logic [7:0]                  port, port_next;
  logic [7:0]                  received, received_next;
  logic [7:0]                  accepted, accepted_next;
  logic [7:0]                  mismatched, mismatched_next;
  logic [7:0]                  b;
  logic [7:0]                  inc;
  logic [1:0]                  ev;

  assign b = request.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= epr_pkg::ST_IDLE;
      check      <= '0;
      fill       <= '0;
      ready      <= 1'b0;
      source     <= '0;
      port       <= '0;
      received   <= '0;
      accepted   <= '0;
      mismatched <= '0;
    end else if (take) begin
      state      <= state_next;
      check      <= check_next;
      fill       <= fill_next;
      ready      <= ready_next;
      source     <= source_next;
      port       <= port_next;
      received   <= received_next;
      accepted   <= accepted_next;
      mismatched <= mismatched_next;
    end
  end

  always_comb begin
    state_next      = state;
    check_next      = check;
    fill_next       = fill;
    ready_next      = ready;
    source_next     = source;
    port_next       = port;
    received_next   = received;
    accepted_next   = accepted;
    mismatched_next = mismatched;
    inc             = '0;
    ev              = epr_pkg::EV_NONE;
    buf_write.en    = 1'b0;
    buf_write.addr  = fill[epr_pkg::BUF_ADDR_W-1:0];
    buf_write.data  = b;

    if (take && request.operation == epr_pkg::OP_RECEIVE) begin
      if (request.line_error) begin
        state_next = epr_pkg::ST_IDLE;
      end else begin
        unique case (state)
          epr_pkg::ST_IDLE: begin
            if (b == cfg.escape_byte) state_next = epr_pkg::ST_ESCAPE;
          end
          epr_pkg::ST_ESCAPE: begin
            if (b == cfg.header_byte) begin
              state_next = epr_pkg::ST_CHECK;
              inc = received + 8'd1;
              if (inc == 8'd0) begin
                received_next   = '0;
                accepted_next   = '0;
                mismatched_next = '0;
              end else begin
                received_next = inc;
              end
            end else begin
              state_next = epr_pkg::ST_IDLE;
            end
          end
          epr_pkg::ST_CHECK: begin
            if (b == cfg.escape_byte) begin
              state_next = epr_pkg::ST_ESCAPE;
            end else begin
              check_next = ~b;
              state_next = epr_pkg::ST_DEST;
            end
          end
          epr_pkg::ST_DEST: begin
            if (b == epr_pkg::ADDR_BASE + {4'b0, cfg.bot_id}) begin
              check_next = check ^ b;
              state_next = epr_pkg::ST_SOURCE;
            end else if (b == cfg.escape_byte) begin
              state_next = epr_pkg::ST_ESCAPE;
            end else begin
              state_next = epr_pkg::ST_IDLE;
            end
          end
          epr_pkg::ST_SOURCE: begin
            if (b == cfg.escape_byte) begin
              state_next = epr_pkg::ST_ESCAPE;
            end else begin
              check_next  = check ^ b;
              source_next = b;
              ready_next  = 1'b0;
              fill_next   = '0;
              state_next  = epr_pkg::ST_PORT;
            end
          end
          epr_pkg::ST_PORT: begin
            if (b == cfg.escape_byte) begin
              state_next = epr_pkg::ST_ESCAPE;
            end else begin
              check_next = check ^ b;
              port_next  = b;
              state_next = epr_pkg::ST_DATA;
            end
          end
          epr_pkg::ST_DATA: begin
            if (fill < epr_pkg::FILL_W'(epr_pkg::BUFFER_DEPTH)) begin
              buf_write.en = 1'b1;
              fill_next    = fill + 1'b1;
              if (b == cfg.escape_byte) state_next = epr_pkg::ST_DATAESC;
              else check_next = check ^ b;
            end else begin
              // buffer full: drop the packet
              state_next = epr_pkg::ST_IDLE;
            end
          end
          epr_pkg::ST_DATAESC: begin
            if (b == cfg.escape_byte) begin
              check_next = check ^ b;
              state_next = epr_pkg::ST_DATA;
            end else if (b == cfg.end_byte) begin
              if (check == 8'd0) begin
                ready_next = 1'b1;
                if (fill != '0) fill_next = fill - 1'b1;
                ev  = epr_pkg::EV_ACCEPT;
                inc = accepted + 8'd1;
                if (inc == 8'd0) begin
                  received_next   = '0;
                  accepted_next   = '0;
                  mismatched_next = '0;
                end else begin
                  accepted_next = inc;
                end
              end else begin
                ev  = epr_pkg::EV_MISMATCH;
                inc = mismatched + 8'd1;
                if (inc == 8'd0) begin
                  received_next   = '0;
                  accepted_next   = '0;
                  mismatched_next = '0;
                end else begin
                  mismatched_next = inc;
                end
              end
              state_next = epr_pkg::ST_IDLE;
            end else begin
              state_next = epr_pkg::ST_IDLE;
            end
          end
          default: state_next = epr_pkg::ST_IDLE;
        endcase
      end
    end

    status.packet_event = ev;
    status.ready        = ready_next;
    status.fill         = fill_next;
    status.source       = source_next;
    status.port         = port_next;
    status.received     = received_next;
    status.accepted     = accepted_next;
    status.mismatched   = mismatched_next;
  end

endmodule

// File: hdl/epr_buffer.sv
// Packet data buffer: one write port from the parser, one read port for requests.
// Depends on epr_pkg.
module epr_buffer (
  input  logic                         clk,
  input  epr_pkg::buf_write_t          buf_write,
  input  logic                         read_en,
  input  logic [epr_pkg::INDEX_W-1:0]  read_index,
  output logic [7:0]                   read_data
);

  logic [7:0] mem [epr_pkg::BUFFER_DEPTH];
  logic       in_range;

  always_ff @(posedge clk) begin
    if (buf_write.en) mem[buf_write.addr] <= buf_write.data;
  end

  assign in_range = {1'b0, read_index} < (epr_pkg::INDEX_W + 1)'(epr_pkg::BUFFER_DEPTH);

  // Return zero on receive and for an index past the end.
  always_comb begin
    read_data = 8'd0;
    if (read_en && in_range) read_data = mem[read_index[epr_pkg::BUF_ADDR_W-1:0]];
  end

endmodule

// File: hdl/epr_result_queue.sv
// Two-entry result queue between the parser and the result channel.
// Depends on epr_pkg.
module epr_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  epr_pkg::result_t push_data,
  output logic             full,
  output logic             result_valid,
  input  logic             result_stall,
  output epr_pkg::result_t result
);

  epr_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = count != 2'd0;
  assign full         = count == 2'd2;
  assign result       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: hdl/escaped_packet_receiver_core.sv
// Escaped packet receiver core: one result per request; each result is written into
// the result queue at the edge that accepts its request.
// Throughput: one request per cycle while a queue slot is free; the parser updates in a single pass
// and a two-entry result queue lets requests keep flowing while a result waits.
// Synchronous active-high reset clears parser state, counters, config
// registers and the queue; the data buffer is not cleared.
// Depends on epr_pkg, epr_parser, epr_buffer, epr_result_queue.
module escaped_packet_receiver_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  epr_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output epr_pkg::result_t  result,
  input  logic              write_enable,
  input  logic [1:0]        write_index,
  input  logic [7:0]        write_data
);

  epr_pkg::config_t      cfg;
  epr_pkg::buf_write_t   buf_write;
  epr_pkg::parse_status_t status;
  epr_pkg::result_t      push_data;
  logic                  take;
  logic                  queue_full;
  logic [7:0]            read_data;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bot_id      <= 4'd0;
      cfg.escape_byte <= 8'd125;
      cfg.header_byte <= 8'd1;
      cfg.end_byte    <= 8'd2;
    end else if (write_enable) begin
      unique case (write_index)
        epr_pkg::REG_BOT_ID:      cfg.bot_id      <= write_data[3:0];
        epr_pkg::REG_ESCAPE_BYTE: cfg.escape_byte <= write_data;
        epr_pkg::REG_HEADER_BYTE: cfg.header_byte <= write_data;
        epr_pkg::REG_END_BYTE:    cfg.end_byte    <= write_data;
        default: ;
      endcase
    end
  end

  // Hold requests only when both queue slots are occupied.
  assign request_stall = queue_full;
  assign take          = request_valid && !queue_full;

  epr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .request   (request),
    .cfg       (cfg),
    .buf_write (buf_write),
    .status    (status)
  );

  // A read request never writes, so the array read sees all earlier writes.
  epr_buffer u_buffer (
    .clk        (clk),
    .buf_write  (buf_write),
    .read_en    (request.operation == epr_pkg::OP_READ),
    .read_index (request.read_index),
    .read_data  (read_data)
  );

  // Assemble the result from the state after this request is applied.
  always_comb begin
    push_data.packet_event   = status.packet_event;
    push_data.packet_ready   = status.ready;
    push_data.packet_length  = 6'(status.fill);
    push_data.source_address = status.source;
    push_data.port_number    = status.port;
    push_data.read_data      = read_data;
    push_data.received_count = status.received;
    push_data.accepted_count = status.accepted;
    push_data.mismatch_count = status.mismatched;
  end

  epr_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (take),
    .push_data    (push_data),
    .full         (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: hdl/epr_checker.sv
// Port-level checks of the escaped packet receiver core, bound to the top level.
// Depends on epr_pkg and escaped_packet_receiver_core.
module epr_checker (
  input logic              clk,
  input logic              rst,
  input logic              request_valid,
  input logic              request_stall,
  input logic              result_valid,
  input logic              result_stall,
  input epr_pkg::result_t  result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_request_result: assert property (@(posedge clk) disable iff (rst)
    request_valid && !request_stall |=> result_valid)
    else $error("accepted request produced no result");

  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.packet_event == epr_pkg::EV_ACCEPT |-> result.packet_ready)
    else $error("accepted packet without ready flag");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.packet_length <= 6'(epr_pkg::BUFFER_DEPTH))
    else $error("packet length beyond buffer depth");

endmodule

bind escaped_packet_receiver_core epr_checker u_epr_checker (
  .clk           (clk),
  .rst           (rst),
  .request_valid (request_valid),
  .request_stall (request_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);

// File: tb/escaped_packet_receiver_checker.sv
`timescale 1ns / 100ps
// Checker for the escaped packet receiver: predicts one result per request and compares.
// Depends on epr_pkg for the request, result and register types.
module escaped_packet_receiver_checker
  import epr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       request_valid,
  input  logic       request_stall,
  input  request_t   request,
  input  logic       result_valid,
  input  logic       result_stall,
  input  result_t    result,
  input  logic       write_enable,
  input  logic [1:0] write_index,
  input  logic [7:0] write_data,
  output int         errors,
  output int         owed,
  output int         checked,
  output int         accepts_seen,
  output int         mismatches_seen
);

  // Shadow copy of the parser and its registers.
  config_t      regs;
  parse_state_t pstate;
  logic [7:0]   chk;
  logic [7:0]   store [BUFFER_DEPTH];
  logic [5:0]   fill;
  logic         ready;
  logic [7:0]   src_reg, port_reg;
  logic [7:0]   n_rx, n_ok, n_bad;

  result_t owed_results [$];
  int fail_total = 0;
  int owed_total = 0;
  int checked_total = 0;
  int accept_total = 0;
  int mismatch_total = 0;

  assign errors = fail_total;
  assign owed = owed_total;
  assign checked = checked_total;
  assign accepts_seen = accept_total;
  assign mismatches_seen = mismatch_total;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_total < 30)
      $display("%0t: %s (result %0d): got 0x%0h, want 0x%0h", $realtime, what,
               checked_total, got, want);
    fail_total++;
  endtask

  function automatic void clear_tallies();
    n_rx = '0;
    n_ok = '0;
    n_bad = '0;
  endfunction

  // Advance the shadow parser by one request and return the result it owes.
  function automatic result_t apply_request(input request_t r);
    result_t    res;
    logic [7:0] b;
    logic [1:0] ev;
    logic [7:0] rd;
    ev = EV_NONE;
    rd = '0;
    b = r.rx_byte;
    if (r.operation == OP_RECEIVE) begin
      if (r.line_error) begin
        pstate = ST_IDLE;
      end else begin
        case (pstate)
          ST_IDLE: begin
            if (b == regs.escape_byte) pstate = ST_ESCAPE;
          end
          ST_ESCAPE: begin
            if (b == regs.header_byte) begin
              pstate = ST_CHECK;
              n_rx = n_rx + 8'd1;
              if (n_rx == 8'd0) clear_tallies();
            end else begin
              pstate = ST_IDLE;
            end
          end
          ST_CHECK: begin
            if (b == regs.escape_byte) begin
              pstate = ST_ESCAPE;
            end else begin
              chk = ~b;
              pstate = ST_DEST;
            end
          end
          ST_DEST: begin
            if (b == ADDR_BASE + {4'd0, regs.bot_id}) begin
              chk = chk ^ b;
              pstate = ST_SOURCE;
            end else if (b == regs.escape_byte) begin
              pstate = ST_ESCAPE;
            end else begin
              pstate = ST_IDLE;
            end
          end
          ST_SOURCE: begin
            if (b == regs.escape_byte) begin
              pstate = ST_ESCAPE;
            end else begin
              chk = chk ^ b;
              src_reg = b;
              ready = 1'b0;
              fill = '0;
              pstate = ST_PORT;
            end
          end
          ST_PORT: begin
            if (b == regs.escape_byte) begin
              pstate = ST_ESCAPE;
            end else begin
              chk = chk ^ b;
              port_reg = b;
              pstate = ST_DATA;
            end
          end
          ST_DATA: begin
            if (fill < BUFFER_DEPTH) begin
              store[fill[4:0]] = b;
              fill = fill + 6'd1;
              if (b == regs.escape_byte) pstate = ST_DATAESC;
              else chk = chk ^ b;
            end else begin
              pstate = ST_IDLE;
            end
          end
          default: begin
            if (b == regs.escape_byte) begin
              chk = chk ^ b;
              pstate = ST_DATA;
            end else if (b == regs.end_byte) begin
              if (chk == 8'd0) begin
                ready = 1'b1;
                if (fill > 0) fill = fill - 6'd1;
                ev = EV_ACCEPT;
                n_ok = n_ok + 8'd1;
                if (n_ok == 8'd0) clear_tallies();
              end else begin
                ev = EV_MISMATCH;
                n_bad = n_bad + 8'd1;
                if (n_bad == 8'd0) clear_tallies();
              end
              pstate = ST_IDLE;
            end else begin
              pstate = ST_IDLE;
            end
          end
        endcase
      end
    end else if (r.read_index < BUFFER_DEPTH) begin
      rd = store[r.read_index];
    end
    res.packet_event = ev;
    res.packet_ready = ready;
    res.packet_length = fill;
    res.source_address = src_reg;
    res.port_number = port_reg;
    res.read_data = rd;
    res.received_count = n_rx;
    res.accepted_count = n_ok;
    res.mismatch_count = n_bad;
    return res;
  endfunction

  // All sampling happens at the rising edge, before the block's registers move.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs = '{bot_id: 4'd0, escape_byte: 8'd125, header_byte: 8'd1, end_byte: 8'd2};
      pstate = ST_IDLE;
      chk = '0;
      fill = '0;
      ready = 1'b0;
      src_reg = '0;
      port_reg = '0;
      clear_tallies();
      owed_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed", 8'(result.packet_event), 8'd0);
        end else begin
          want = owed_results.pop_front();
          if (result.packet_event != want.packet_event)
            report_mismatch("packet_event", 8'(result.packet_event),
                            8'(want.packet_event));
          if (result.packet_ready != want.packet_ready)
            report_mismatch("packet_ready", 8'(result.packet_ready),
                            8'(want.packet_ready));
          if (result.packet_length != want.packet_length)
            report_mismatch("packet_length", 8'(result.packet_length),
                            8'(want.packet_length));
          if (result.source_address != want.source_address)
            report_mismatch("source_address", result.source_address, want.source_address);
          if (result.port_number != want.port_number)
            report_mismatch("port_number", result.port_number, want.port_number);
          if (result.read_data != want.read_data)
            report_mismatch("read_data", result.read_data, want.read_data);
          if (result.received_count != want.received_count)
            report_mismatch("received_count", result.received_count, want.received_count);
          if (result.accepted_count != want.accepted_count)
            report_mismatch("accepted_count", result.accepted_count, want.accepted_count);
          if (result.mismatch_count != want.mismatch_count)
            report_mismatch("mismatch_count", result.mismatch_count, want.mismatch_count);
          if (want.packet_event == EV_ACCEPT) accept_total++;
          if (want.packet_event == EV_MISMATCH) mismatch_total++;
          checked_total++;
        end
      end
      if (write_enable) begin
        case (write_index)
          REG_BOT_ID:      regs.bot_id = write_data[3:0];
          REG_ESCAPE_BYTE: regs.escape_byte = write_data;
          REG_HEADER_BYTE: regs.header_byte = write_data;
          default:         regs.end_byte = write_data;
        endcase
      end
      if (request_valid && !request_stall) owed_results.push_back(apply_request(request));
    end
    owed_total = owed_results.size();
  end

endmodule

// File: tb/tb_escaped_packet_receiver_core.sv
`timescale 1ns / 100ps
// Top of the escaped packet receiver bench: clock, reset, request stimulus and verdict.
// Depends on epr_pkg, escaped_packet_receiver_core and escaped_packet_receiver_checker.
module tb_escaped_packet_receiver_core;
  import epr_pkg::*;

  // Result-side stall behavior, picked anew at random for each span.
  typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

  localparam int HOLD_OFF_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       request_valid = 1'b0;
  logic       request_stall;
  request_t   request = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       write_enable = 1'b0;
  logic [1:0] write_index = REG_BOT_ID;
  logic [7:0] write_data = '0;

  int errors, owed, checked, accepts_seen, mismatches_seen;

  // Register values as last written; packets are built from these.
  config_t     line_cfg = '{bot_id: 4'd0, escape_byte: 8'd125, header_byte: 8'd1,
                            end_byte: 8'd2};
  int unsigned burst_left = 0;
  int          requests_sent = 0;
  bit          hold_req = 1'b0;
  bit          hold_served = 1'b0;

  escaped_packet_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .write_enable  (write_enable),
    .write_index   (write_index),
    .write_data    (write_data)
  );

  escaped_packet_receiver_checker monitor_chk (
    .clk             (clk),
    .rst             (rst),
    .request_valid   (request_valid),
    .request_stall   (request_stall),
    .request         (request),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .errors          (errors),
    .owed            (owed),
    .checked         (checked),
    .accepts_seen    (accepts_seen),
    .mismatches_seen (mismatches_seen)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block wedges.
  initial begin : watchdog
    #2000000;
    $display("Timed out with %0d results still owed", owed);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall on a pattern of its own, with one long hold-off on request
  // so that the result queue fills and the block stalls the sender.
  initial begin : receiver
    stall_mode_t mode;
    int unsigned span;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        if (hold_req && !hold_served) begin
          hold_served = 1'b1;
          result_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        case (mode)
          FLOW:    result_stall <= 1'b0;
          LIGHT:   result_stall <= ($urandom_range(0, 3) == 0);
          HEAVY:   result_stall <= ($urandom_range(0, 9) < 7);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  // Offer one request and hold it until the block takes it. Bursts of random
  // length are separated by random gaps; now and then a long burst with no gap.
  task automatic offer(input request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      request_valid <= 1'b0;
      request <= 'x ^ 'x;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    request_valid <= 1'b1;
    request <= r;
    do @(posedge clk); while (request_stall);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic err);
    request_t r;
    r.operation = OP_RECEIVE;
    r.rx_byte = b;
    r.line_error = err;
    r.read_index = 5'($urandom);
    offer(r);
  endtask

  // Rx byte and error flag are don't-care on a read; randomize them anyway.
  task automatic send_read(input logic [4:0] idx);
    request_t r;
    r.operation = OP_READ;
    r.rx_byte = 8'($urandom);
    r.line_error = 1'($urandom);
    r.read_index = idx;
    offer(r);
  endtask

  // Bias data toward the framing codes so escapes and look-alikes show up often.
  function automatic logic [7:0] pick_data_byte();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 3) return line_cfg.escape_byte;
    if (roll == 3) return line_cfg.end_byte;
    if (roll == 4) return line_cfg.header_byte;
    return 8'($urandom);
  endfunction

  // Send a whole framed packet. The checksum byte is the inverse of the XOR of
  // destination, source, port and data; a doubled escape counts once.
  // Keep the escape code out of checksum, source and port so the frame always
  // reaches its data; escapes in those places are sent on their own.
  task automatic send_packet(input int len, input bit bad_sum, input bit bad_dest);
    logic [7:0] dest, src, prt, sum, body_sum, d;
    logic [7:0] body [$];
    dest = ADDR_BASE + {4'd0, line_cfg.bot_id};
    if (bad_dest) dest = dest ^ 8'($urandom_range(1, 255));
    body_sum = '0;
    repeat (len) begin
      d = pick_data_byte();
      body.push_back(d);
      body_sum = body_sum ^ d;
    end
    do begin
      src = 8'($urandom);
      prt = 8'($urandom);
      sum = ~(dest ^ src ^ prt ^ body_sum);
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    end while (src == line_cfg.escape_byte || prt == line_cfg.escape_byte ||
               sum == line_cfg.escape_byte);
    send_byte(line_cfg.escape_byte, 1'b0);
    send_byte(line_cfg.header_byte, 1'b0);
    send_byte(sum, 1'b0);
    send_byte(dest, 1'b0);
    send_byte(src, 1'b0);
    send_byte(prt, 1'b0);
    foreach (body[i]) begin
      send_byte(body[i], 1'b0);
      if (body[i] == line_cfg.escape_byte) send_byte(body[i], 1'b0);
    end
    send_byte(line_cfg.escape_byte, 1'b0);
    send_byte(line_cfg.end_byte, 1'b0);
  endtask

  // Start a packet and break it inside the data: either a line error or an
  // escape followed by something that is neither escape nor end code.
  task automatic send_broken(input bit by_error);
    logic [7:0] stray;
    send_byte(line_cfg.escape_byte, 1'b0);
    send_byte(line_cfg.header_byte, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(ADDR_BASE + {4'd0, line_cfg.bot_id}, 1'b0);
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b0);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    if (by_error) begin
      send_byte(8'($urandom), 1'b1);
    end else begin
      do stray = 8'($urandom);
      while (stray == line_cfg.escape_byte || stray == line_cfg.end_byte);
      send_byte(line_cfg.escape_byte, 1'b0);
      send_byte(stray, 1'b0);
    end
  endtask

  // Drop valid and wait until every owed result is back.
  task automatic settle();
    @(negedge clk);
    request_valid <= 1'b0;
    while (owed != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic program_regs(input config_t c);
    settle();
    write_reg(REG_BOT_ID, {4'd0, c.bot_id});
    write_reg(REG_ESCAPE_BYTE, c.escape_byte);
    write_reg(REG_HEADER_BYTE, c.header_byte);
    write_reg(REG_END_BYTE, c.end_byte);
    line_cfg = c;
  endtask

  // Mostly well-formed packets with random content, the rest noise, reads and
  // broken frames. Every buffer entry is written before this runs.
  task automatic random_traffic(input int quota, input bit with_hold_off);
    int start, pick, len;
    start = requests_sent;
    while (requests_sent - start < quota) begin
      if (with_hold_off && requests_sent - start > quota / 3) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
      if (pick < 55) send_packet(len, 1'b0, 1'b0);
      else if (pick < 63) send_packet(len, 1'b1, 1'b0);
      else if (pick < 68) send_packet(len, 1'b0, 1'b1);
      else if (pick < 76) repeat ($urandom_range(1, 4)) send_read(5'($urandom));
      else if (pick < 84)
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      else if (pick < 92) send_broken(1'($urandom));
      else begin
        send_byte(line_cfg.escape_byte, 1'b0);
        send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    config_t rc;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset register values. Line errors, including one on an escape.
    send_byte(line_cfg.escape_byte, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Escape followed by a wrong header code.
    send_byte(line_cfg.escape_byte, 1'b0);
    send_byte(8'h55, 1'b0);
    // 31 data bytes plus the stored closing escape write every buffer entry,
    // so reads are safe from here on.
    send_packet(31, 1'b0, 1'b0);
    send_read(5'd0);
    send_read(5'd31);
    // Escape where checksum, destination, source and port are expected: the
    // prefix is cut short and the next packet's escape restarts the frame.
    for (int depth = 1; depth <= 4; depth++) begin
      send_byte(line_cfg.escape_byte, 1'b0);
      send_byte(line_cfg.header_byte, 1'b0);
      if (depth >= 2) send_byte(8'h33, 1'b0);
      if (depth >= 3) send_byte(ADDR_BASE + {4'd0, line_cfg.bot_id}, 1'b0);
      if (depth >= 4) send_byte(8'h44, 1'b0);
      send_packet(3, 1'b0, 1'b0);
    end
    send_packet(2, 1'b0, 1'b1);   // wrong destination
    send_packet(4, 1'b1, 1'b0);   // checksum mismatch
    send_packet(0, 1'b0, 1'b0);   // empty payload
    send_broken(1'b0);
    send_broken(1'b1);
    send_packet(32, 1'b0, 1'b0);  // closing escape hits a full buffer
    send_read(5'd17);

    // Extreme register settings, then a random one with distinct codes.
    program_regs('{bot_id: 4'hF, escape_byte: 8'hFF, header_byte: 8'h00, end_byte: 8'h80});
    random_traffic(60, 1'b0);
    program_regs('{bot_id: 4'h0, escape_byte: 8'h00, header_byte: 8'hFF, end_byte: 8'h7F});
    random_traffic(60, 1'b0);
    do begin
      rc.bot_id = 4'($urandom);
      rc.escape_byte = 8'($urandom);
      rc.header_byte = 8'($urandom);
      rc.end_byte = 8'($urandom);
    end while (rc.escape_byte == rc.header_byte || rc.escape_byte == rc.end_byte ||
               rc.header_byte == rc.end_byte);
    program_regs(rc);
    random_traffic(80, 1'b1);

    // Drain, bounded; the watchdog catches a hard hang.
    @(negedge clk);
    request_valid <= 1'b0;
    for (int n = 0; n < 20000 && owed != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests over four register settings; %0d results checked.",
             requests_sent, checked);
    $display("Packets closed: %0d accepted, %0d checksum mismatches; one %0d-cycle hold-off.",
             accepts_seen, mismatches_seen, HOLD_OFF_CYCLES);
    if (owed != 0) $display("%0d results never arrived", owed);
    if (errors == 0 && owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
